// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

  localparam int KIND_W = 2;
  localparam int CHAR_W = 8;
  localparam int ADDR_W = 11;
  localparam int ATTR_W = 8;
  localparam int CELL_W = 16;
  localparam int OCOL_W = 7;
  localparam int OROW_W = 5;
  localparam int OLOC_W = 11;

  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 40;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LAST_PRINT = 8'h7F;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_COPY,
    ST_FILL,
    ST_READ,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic capture;
    logic home;
    logic do_put;
    logic do_read;
    logic cnt_zero;
    logic cnt_inc;
    logic copy_step;
    logic fill_step;
    logic fill_reset_attr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_scroll;
    logic copy_last;
    logic fill_last;
  } sts_t;

endpackage

// ----- rtl/tcw_ctrl.sv -----
module tcw_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  tcw_pkg::kind_t in_kind,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  tcw_pkg::sts_t sts,
  output tcw_pkg::cmd_t cmd
);
  import tcw_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   slot_free;
  logic   take;

  function automatic state_t dispatch(input kind_t k);
    state_t s;
    case (k)
      KIND_PUT:   s = ST_PUT;
      KIND_CLEAR: s = ST_FILL;
      KIND_READ:  s = ST_READ;
      default:    s = ST_RESULT;
    endcase
    return s;
  endfunction

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) || ((state_r == ST_RESULT) && slot_free);
  assign take = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (sts.fill_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (take) state_nxt = dispatch(in_kind);
      end
      ST_PUT: begin
        state_nxt = sts.need_scroll ? ST_COPY : ST_RESULT;
      end
      ST_COPY: begin
        if (sts.copy_last) state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (sts.fill_last) state_nxt = ST_RESULT;
      end
      ST_READ: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (slot_free) state_nxt = take ? dispatch(in_kind) : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_INIT: begin
        cmd.fill_step = 1'b1;
        cmd.fill_reset_attr = 1'b1;
        cmd.cnt_inc = !sts.fill_last;
      end
      ST_IDLE: begin
        cmd.capture = take;
        cmd.cnt_zero = take && (in_kind == KIND_CLEAR);
        cmd.home = take && (in_kind == KIND_CLEAR);
      end
      ST_PUT: begin
        cmd.do_put = 1'b1;
        cmd.cnt_zero = sts.need_scroll;
      end
      ST_COPY: begin
        cmd.copy_step = 1'b1;
        cmd.cnt_inc = !sts.copy_last;
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        cmd.cnt_inc = !sts.fill_last;
      end
      ST_READ: begin
        cmd.do_read = 1'b1;
      end
      ST_RESULT: begin
        cmd.load_out = slot_free;
        cmd.capture = take;
        cmd.cnt_zero = take && (in_kind == KIND_CLEAR);
        cmd.home = take && (in_kind == KIND_CLEAR);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/tcw_datapath.sv -----
module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tcw_pkg::cmd_t                 cmd,
  output tcw_pkg::sts_t                 sts,
  input  logic [tcw_pkg::KIND_W-1:0]    in_kind,
  input  logic [tcw_pkg::CHAR_W-1:0]    in_char,
  input  logic [tcw_pkg::ADDR_W-1:0]    in_addr,
  input  logic                          cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]    cfg_attr,
  output logic [tcw_pkg::OUT_DATA_W-1:0] out_data
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW = $clog2(CELLS);
  localparam int CW = $clog2(COLUMNS + TAB_WIDTH);
  localparam int RW = $clog2(ROWS + 1);
  localparam int PW = (TAB_WIDTH > 2) ? $clog2(TAB_WIDTH) : 1;

  logic [CELL_W-1:0] mem [CELLS];

  logic [ATTR_W-1:0] attr_r;
  logic [CHAR_W-1:0] char_r;
  logic [AW-1:0]     addr_r;
  logic              rd_ok_r;
  logic              scrolled_r;
  logic [CW-1:0]     col_r;
  logic [CW-1:0]     col_nxt;
  logic [RW-1:0]     row_r;
  logic [RW-1:0]     row_nxt;
  logic [PW-1:0]     phase_r;
  logic [PW-1:0]     phase_nxt;
  logic [AW-1:0]     cnt_r;
  logic [CELL_W-1:0] rdata_r;

  logic [CW-1:0]     col_a;
  logic [RW-1:0]     row_a;
  logic [PW-1:0]     phase_a;
  logic              printable;
  logic [AW-1:0]     loc;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [CELL_W-1:0] wdata;
  logic              re;
  logic [AW-1:0]     raddr;

  logic [OCOL_W-1:0] ocol_r;
  logic [OROW_W-1:0] orow_r;
  logic [OLOC_W-1:0] oloc_r;
  logic [CELL_W-1:0] ocell_r;
  logic              oscr_r;

  assign loc = AW'(row_r * COLUMNS) + AW'(col_r);
  assign printable = (char_r >= CH_SPACE) && (char_r <= CH_LAST_PRINT);

  always_comb begin
    col_a = col_r;
    row_a = row_r;
    phase_a = phase_r;
    if (char_r == CH_BACKSPACE) begin
      if (col_r != '0) begin
        col_a = col_r - CW'(1);
        phase_a = (phase_r == '0) ? PW'(TAB_WIDTH - 1) : phase_r - PW'(1);
      end
    end else if (char_r == CH_TAB) begin
      col_a = col_r + CW'(TAB_WIDTH) - CW'(phase_r);
      phase_a = '0;
    end else if (char_r == CH_CR) begin
      col_a = '0;
      phase_a = '0;
    end else if (char_r == CH_LF) begin
      col_a = '0;
      phase_a = '0;
      row_a = row_r + RW'(1);
    end else if (printable) begin
      col_a = col_r + CW'(1);
      phase_a = (phase_r == PW'(TAB_WIDTH - 1)) ? '0 : phase_r + PW'(1);
    end
    if (col_a >= CW'(COLUMNS)) begin
      col_a = '0;
      phase_a = '0;
      row_a = row_a + RW'(1);
    end
  end

  assign sts.need_scroll = (row_a == RW'(ROWS));
  assign sts.copy_last = (cnt_r == AW'(CELLS - COLUMNS));
  assign sts.fill_last = (cnt_r == AW'(CELLS - 1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    phase_nxt = phase_r;
    if (cmd.home) begin
      col_nxt = '0;
      row_nxt = '0;
      phase_nxt = '0;
    end else if (cmd.do_put) begin
      col_nxt = col_a;
      phase_nxt = phase_a;
      row_nxt = sts.need_scroll ? RW'(ROWS - 1) : row_a;
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = cnt_r;
    wdata = {(cmd.fill_reset_attr ? RESET_ATTR : attr_r), CH_SPACE};
    re = 1'b0;
    raddr = addr_r;
    if (cmd.do_put) begin
      we = printable;
      waddr = loc;
      wdata = {attr_r, char_r};
    end else if (cmd.copy_step) begin
      we = (cnt_r != '0);
      waddr = cnt_r - AW'(1);
      wdata = rdata_r;
      re = !sts.copy_last;
      raddr = AW'(cnt_r + AW'(COLUMNS));
    end else if (cmd.fill_step) begin
      we = 1'b1;
    end else if (cmd.do_read) begin
      re = rd_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= RESET_ATTR;
      col_r <= '0;
      row_r <= '0;
      phase_r <= '0;
      cnt_r <= '0;
      rd_ok_r <= 1'b0;
      scrolled_r <= 1'b0;
    end else begin
      if (cfg_we) attr_r <= cfg_attr;
      col_r <= col_nxt;
      row_r <= row_nxt;
      phase_r <= phase_nxt;
      if (cmd.cnt_zero) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + AW'(1);
      end
      if (cmd.capture) begin
        rd_ok_r <= (kind_t'(in_kind) == KIND_READ) && (32'(in_addr) < CELLS);
        scrolled_r <= 1'b0;
      end else if (cmd.do_put && sts.need_scroll) begin
        scrolled_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      char_r <= in_char;
      addr_r <= AW'(in_addr);
    end
    if (cmd.load_out) begin
      ocol_r <= OCOL_W'(col_r);
      orow_r <= OROW_W'(row_r);
      oloc_r <= OLOC_W'(loc);
      ocell_r <= rd_ok_r ? rdata_r : '0;
      oscr_r <= scrolled_r;
    end
  end

  assign out_data = {oscr_r, ocell_r, oloc_r, orow_r, ocol_r};

endmodule

// ----- rtl/text_console_writer.sv -----
// Text console writer with a COLUMNS x ROWS cell store and a cursor.
// The in_ channel carries one item per transfer: put a character, clear the
// screen, or read one cell. Each item produces exactly one transfer on the
// out_ channel with the cursor position after the item, the cell read for a
// read item (zero otherwise) and a flag that marks a scroll.
// The cfg_ channel writes the attribute byte used for new and blank cells;
// it is always ready and should only be written while the block is idle.
// A character or read item goes through ST_PUT or ST_READ to ST_RESULT (a
// scroll adds ST_COPY and ST_FILL), an unused kind goes straight to ST_RESULT,
// and the next input transfer can be taken as ST_RESULT loads the result. A
// scroll copies the store one cell per cycle through the single memory port
// pair and then blanks the bottom line; a clear writes every cell. After reset
// the block blanks the store with attribute 0x0F and holds in_tready low
// meanwhile.
// The result sits in an output register, so the next input is taken while a
// result waits; if the receiver stalls, the block holds the following result
// in place and stops taking input until the output register frees up.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // kind [1:0]
  input  logic [tcw_pkg::KIND_W-1:0]     in_tuser,
  // character [7:0], cell_address [18:8], zero fill above
  input  logic [tcw_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // cursor_column [6:0], cursor_row [11:7], cursor_offset [22:12],
  // cell_data [38:23], scrolled [39]
  output logic [tcw_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tcw_pkg::ATTR_W-1:0]     cfg_data
);
  import tcw_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [KIND_W-1:0] in_kind;
  logic [CHAR_W-1:0] in_char;
  logic [ADDR_W-1:0] in_addr;

  assign in_kind = in_tuser;
  assign in_char = in_tdata[CHAR_W-1:0];
  assign in_addr = in_tdata[CHAR_W+ADDR_W-1:CHAR_W];
  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_kind    (kind_t'(in_kind)),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tcw_datapath #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_kind  (in_kind),
    .in_char  (in_char),
    .in_addr  (in_addr),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_attr (cfg_data),
    .out_data (out_tdata)
  );

endmodule
